// File: design/csv_byte_tokenizer_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef CSV_BYTE_TOKENIZER_UNIT_DEFINES_SVH
`define CSV_BYTE_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define CSVBT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csvbt check failed");

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define CSVBT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csvbt check failed");

`endif

// File: design/csvbt_pkg.sv
`default_nettype none

package csvbt_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] SEP_RESET = 8'h2C;

    // Field count saturates here (MAX_FIELDS capped to the 8-bit count).
    localparam int unsigned MAX_FIELDS = 255;
    localparam logic [7:0]  FIELD_CAP  = (MAX_FIELDS > 255) ? 8'd255 : 8'(MAX_FIELDS);

    // Result queue
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned PTR_W  = $clog2(QDEPTH);
    localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_FIELD = 2'd1,
        KIND_ROW   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] content;
        logic [7:0] field_count;
        logic       last_of_run;
    } t_result;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v < FIELD_CAP) ? v + 8'd1 : FIELD_CAP;
    endfunction

endpackage

`default_nettype wire

// File: design/csv_byte_tokenizer_unit.sv
// CSV byte tokenizer. Takes one byte of text per input beat (i_last_byte on
// the final byte) and emits content bytes, end-of-field marks and end-of-row
// marks carrying the row's saturating field count. The parsing state is
// updated in the cycle a byte is accepted, so a byte is taken every ready
// clock; results go into a 4-entry result queue that feeds the output port,
// one result per beat. A byte that makes two results (a separator or content
// byte that also closes the text) occupies two output beats, so the rate is
// one byte per clock as long as the consumer keeps up and most bytes make at
// most one result. o_in_ready is high while the queue has two free slots.
// The separator register may be written at any time (o_cfg_ready is always
// high) but should only change while the block is idle.
`default_nettype none

module csv_byte_tokenizer_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // byte input
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    // result output
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_content,
    output logic [7:0]      o_field_count,
    output logic            o_last_of_run,
    // separator register
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    logic [7:0] r_separator;

    logic       r_in_quotes,      n_in_quotes;
    logic       r_quote_pending,  n_quote_pending;
    logic       r_after_cr,       n_after_cr;
    logic       r_field_nonempty, n_field_nonempty;
    logic [7:0] r_fields_done,    n_fields_done;

    csvbt_pkg::t_result r_queue [csvbt_pkg::QDEPTH];
    logic [csvbt_pkg::PTR_W-1:0] r_head, r_tail, w_tail_nx;
    logic [csvbt_pkg::CNT_W-1:0] r_count;

    logic               w_accept, w_pop, w_skip;
    logic               w_byte_valid, w_row_valid;
    csvbt_pkg::t_result w_byte_res, w_row_res, w_first, w_second;
    logic [1:0]         w_push;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_count <= csvbt_pkg::CNT_W'(csvbt_pkg::QDEPTH - 2));
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != '0);
    assign w_pop       = o_out_valid && i_out_ready;
    assign w_skip      = r_after_cr && (i_data_byte == csvbt_pkg::CH_LF);

    // Parse step: at most one result from the byte itself, plus a row close
    // when the text ends.
    always_comb begin
        n_in_quotes      = r_in_quotes;
        n_quote_pending  = r_quote_pending;
        n_after_cr       = 1'b0;
        n_field_nonempty = r_field_nonempty;
        n_fields_done    = r_fields_done;

        w_byte_valid = 1'b0;
        w_byte_res   = '{kind: csvbt_pkg::KIND_BYTE, content: 8'd0,
                         field_count: 8'd0, last_of_run: 1'b0};
        w_row_valid  = 1'b0;
        w_row_res    = '{kind: csvbt_pkg::KIND_ROW, content: 8'd0,
                         field_count: 8'd0, last_of_run: 1'b1};

        if (!w_skip) begin
            if (r_in_quotes && !r_quote_pending) begin
                if (i_data_byte == csvbt_pkg::CH_QUOTE) begin
                    n_quote_pending = 1'b1;
                end else begin
                    w_byte_valid       = 1'b1;
                    w_byte_res.content = i_data_byte;
                    n_field_nonempty   = 1'b1;
                end
            end else if (r_in_quotes && i_data_byte == csvbt_pkg::CH_QUOTE) begin
                // doubled quote: one literal quote, stay quoted
                n_quote_pending    = 1'b0;
                w_byte_valid       = 1'b1;
                w_byte_res.content = csvbt_pkg::CH_QUOTE;
                n_field_nonempty   = 1'b1;
            end else begin
                // unquoted byte, or the byte that closes a quoted stretch
                n_in_quotes     = 1'b0;
                n_quote_pending = 1'b0;
                if (i_data_byte == csvbt_pkg::CH_QUOTE && !r_field_nonempty) begin
                    n_in_quotes = 1'b1;
                end else if (i_data_byte == r_separator) begin
                    w_byte_valid     = 1'b1;
                    w_byte_res.kind  = csvbt_pkg::KIND_FIELD;
                    n_fields_done    = csvbt_pkg::sat_inc(r_fields_done);
                    n_field_nonempty = 1'b0;
                end else if (i_data_byte == csvbt_pkg::CH_CR ||
                             i_data_byte == csvbt_pkg::CH_LF) begin
                    w_row_valid = (r_fields_done != 8'd0) || r_field_nonempty;
                    w_row_res.field_count = csvbt_pkg::sat_inc(r_fields_done);
                    n_fields_done    = 8'd0;
                    n_field_nonempty = 1'b0;
                    n_after_cr       = (i_data_byte == csvbt_pkg::CH_CR);
                end else begin
                    w_byte_valid       = 1'b1;
                    w_byte_res.content = i_data_byte;
                    n_field_nonempty   = 1'b1;
                end
            end
        end

        if (i_last_byte) begin
            // close an open row and drop any open quoting
            if (n_fields_done != 8'd0 || n_field_nonempty) begin
                w_row_valid           = 1'b1;
                w_row_res.field_count = csvbt_pkg::sat_inc(n_fields_done);
            end
            n_fields_done    = 8'd0;
            n_field_nonempty = 1'b0;
            n_in_quotes      = 1'b0;
            n_quote_pending  = 1'b0;
            n_after_cr       = 1'b0;
        end
    end

    always_comb begin
        w_first             = w_byte_valid ? w_byte_res : w_row_res;
        w_first.last_of_run = !(w_byte_valid && w_row_valid);
        w_second            = w_row_res;
        w_push              = w_accept ? ({1'b0, w_byte_valid} + {1'b0, w_row_valid})
                                       : 2'd0;
    end

    assign w_tail_nx = r_tail + csvbt_pkg::PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_separator      <= csvbt_pkg::SEP_RESET;
            r_in_quotes      <= 1'b0;
            r_quote_pending  <= 1'b0;
            r_after_cr       <= 1'b0;
            r_field_nonempty <= 1'b0;
            r_fields_done    <= 8'd0;
            r_head           <= '0;
            r_tail           <= '0;
            r_count          <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_separator <= i_cfg_data;
            end
            if (w_accept) begin
                r_in_quotes      <= n_in_quotes;
                r_quote_pending  <= n_quote_pending;
                r_after_cr       <= n_after_cr;
                r_field_nonempty <= n_field_nonempty;
                r_fields_done    <= n_fields_done;
            end
            if (w_pop) begin
                r_head <= r_head + csvbt_pkg::PTR_W'(1);
            end
            r_tail  <= r_tail + csvbt_pkg::PTR_W'(w_push);
            r_count <= r_count + csvbt_pkg::CNT_W'(w_push) - csvbt_pkg::CNT_W'(w_pop);
        end
    end

    // queue payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_push != 2'd0) begin
            r_queue[r_tail] <= w_first;
        end
        if (w_push == 2'd2) begin
            r_queue[w_tail_nx] <= w_second;
        end
    end

    assign o_kind        = r_queue[r_head].kind;
    assign o_content     = r_queue[r_head].content;
    assign o_field_count = r_queue[r_head].field_count;
    assign o_last_of_run = r_queue[r_head].last_of_run;

endmodule

`default_nettype wire

// File: design/csvbt_checker.sv
`default_nettype none
`include "csv_byte_tokenizer_unit_defines.svh"

module csvbt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] o_kind,
    input wire logic [7:0] o_content,
    input wire logic [7:0] o_field_count
);

    localparam logic [1:0] K_BYTE = csvbt_pkg::KIND_BYTE;
    localparam logic [1:0] K_ROW  = csvbt_pkg::KIND_ROW;

    // payload fields that do not belong to the kind stay zero
    `CSVBT_ASSERT_NOW(a_count_zero, o_out_valid && o_kind != K_ROW, o_field_count == 8'd0)
    `CSVBT_ASSERT_NOW(a_content_zero, o_out_valid && o_kind != K_BYTE, o_content == 8'd0)
    // a blank row never reaches the output
    `CSVBT_ASSERT_NOW(a_row_nonempty, o_out_valid && o_kind == K_ROW, o_field_count != 8'd0)
    // hold a stalled beat
    `CSVBT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_kind) && $stable(o_content) && $stable(o_field_count))

endmodule

bind csv_byte_tokenizer_unit csvbt_checker u_csvbt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_kind        (o_kind),
    .o_content     (o_content),
    .o_field_count (o_field_count)
);

`default_nettype wire

// File: bench/tb_csv_byte_tokenizer_unit.sv
`timescale 1ns / 1ps

module tb_csv_byte_tokenizer_unit;
    import csvbt_pkg::*;

    localparam int SETTLE      = 8;
    localparam int DRAIN_LIMIT = 50000;
    localparam int PHASES      = 9;

    typedef struct packed {
        logic [7:0] d;
        logic       l;
    } t_text_byte;

    // Expected token stream built from a running model of the parser state.
    class csv_scoreboard;
        t_result    expected[$];
        t_result    run_buf[$];
        logic [7:0] sep;
        bit         in_q;
        bit         pend;
        bit         aft_cr;
        bit         nonempty;
        logic [7:0] nfields;
        int         errors;
        int         n_bytes;
        int         n_results;
        int         n_rows;

        function new();
            sep      = SEP_RESET;
            in_q     = 0;
            pend     = 0;
            aft_cr   = 0;
            nonempty = 0;
            nfields  = 8'd0;
            errors   = 0;
            n_bytes  = 0;
            n_results = 0;
            n_rows   = 0;
        endfunction

        function void set_separator(logic [7:0] v);
            sep = v;
        endfunction

        function void add(t_kind k, logic [7:0] c, logic [7:0] n);
            t_result r;
            r.kind        = k;
            r.content     = c;
            r.field_count = n;
            r.last_of_run = 1'b0;
            run_buf.push_back(r);
        endfunction

        function void close_row();
            if (nfields != 8'd0 || nonempty)
                add(KIND_ROW, 8'h00, (nfields < FIELD_CAP) ? 8'(nfields + 8'd1) : FIELD_CAP);
            nfields  = 8'd0;
            nonempty = 0;
        endfunction

        // Byte seen outside quotes; separator wins over line end.
        function void unquoted_byte(logic [7:0] c);
            if (c == CH_QUOTE && !nonempty) begin
                in_q = 1;
            end else if (c == sep) begin
                add(KIND_FIELD, 8'h00, 8'h00);
                if (nfields < FIELD_CAP)
                    nfields = 8'(nfields + 8'd1);
                nonempty = 0;
            end else if (c == CH_CR || c == CH_LF) begin
                close_row();
                if (c == CH_CR)
                    aft_cr = 1;
            end else begin
                add(KIND_BYTE, c, 8'h00);
                nonempty = 1;
            end
        endfunction

        function void note_byte(logic [7:0] d, logic l);
            bit      skip;
            t_result r;
            skip = 0;
            run_buf.delete();
            n_bytes++;
            if (aft_cr) begin
                aft_cr = 0;
                if (d == CH_LF)
                    skip = 1;
            end
            if (!skip) begin
                if (in_q) begin
                    if (pend) begin
                        pend = 0;
                        if (d == CH_QUOTE) begin
                            add(KIND_BYTE, CH_QUOTE, 8'h00);
                            nonempty = 1;
                        end else begin
                            in_q = 0;
                            unquoted_byte(d);
                        end
                    end else if (d == CH_QUOTE) begin
                        pend = 1;
                    end else begin
                        add(KIND_BYTE, d, 8'h00);
                        nonempty = 1;
                    end
                end else begin
                    unquoted_byte(d);
                end
            end
            if (l) begin
                close_row();
                in_q   = 0;
                pend   = 0;
                aft_cr = 0;
            end
            if (run_buf.size() > 0) begin
                r = run_buf.pop_back();
                r.last_of_run = 1'b1;
                run_buf.push_back(r);
            end
            foreach (run_buf[i])
                expected.push_back(run_buf[i]);
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] content,
                                   logic [7:0] count, logic last);
            t_result e;
            if (expected.size() == 0) begin
                $error("unexpected result: kind %0d content %02h field_count %0d last %0b",
                       kind, content, count, last);
                errors++;
                return;
            end
            e = expected.pop_front();
            n_results++;
            if (e.kind == KIND_ROW)
                n_rows++;
            if (kind !== e.kind) begin
                $error("kind: expected %0d, got %0d", e.kind, kind);
                errors++;
            end
            if (content !== e.content) begin
                $error("content: expected %02h, got %02h", e.content, content);
                errors++;
            end
            if (count !== e.field_count) begin
                $error("field_count: expected %0d, got %0d", e.field_count, count);
                errors++;
            end
            if (last !== e.last_of_run) begin
                $error("last_of_run: expected %0b, got %0b", e.last_of_run, last);
                errors++;
            end
        endfunction

        function void drain_check();
            if (expected.size() > 0) begin
                $error("%0d expected results never arrived", expected.size());
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       tx_valid = 1'b0;
    logic [7:0] tx_data = 8'h00;
    logic       tx_last = 1'b0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data = 8'h00;

    wire        o_in_ready;
    wire        o_out_valid;
    wire [1:0]  o_kind;
    wire [7:0]  o_content;
    wire [7:0]  o_field_count;
    wire        o_last_of_run;
    wire        o_cfg_ready;

    csv_scoreboard sb;
    t_text_byte    text_q[$];
    int            send_idle = 0;
    int            recv_stall = 0;
    int            items_sent = 0;
    int            n_seps = 0;
    logic [7:0]    sep_list[PHASES];

    csv_byte_tokenizer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (tx_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (tx_data),
        .i_last_byte   (tx_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_kind        (o_kind),
        .o_content     (o_content),
        .o_field_count (o_field_count),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready)
            sb.check_result(o_kind, o_content, o_field_count, o_last_of_run);
    end

    function automatic void push_tx(logic [7:0] d, logic l);
        t_text_byte t;
        t.d = d;
        t.l = l;
        text_q.push_back(t);
    endfunction

    // Byte with no meaning to the parser under the current separator.
    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == sb.sep || c == CH_QUOTE || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic void add_field();
        int         len;
        logic [7:0] c;
        len = $urandom_range(0, 4);
        if ($urandom_range(0, 2) == 0) begin
            push_tx(CH_QUOTE, 1'b0);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        push_tx(CH_QUOTE, 1'b0);
                        push_tx(CH_QUOTE, 1'b0);
                    end
                    1: push_tx(sb.sep, 1'b0);
                    2: push_tx($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
                    default: begin
                        c = 8'($urandom_range(0, 255));
                        push_tx(c, 1'b0);
                        if (c == CH_QUOTE)
                            push_tx(CH_QUOTE, 1'b0);
                    end
                endcase
            end
            push_tx(CH_QUOTE, 1'b0);
        end else begin
            for (int k = 0; k < len; k++) begin
                if (k > 0 && $urandom_range(0, 9) == 0)
                    push_tx(CH_QUOTE, 1'b0);
                else
                    push_tx(pick_plain(), 1'b0);
            end
        end
    endfunction

    function automatic void add_line_end();
        case ($urandom_range(0, 2))
            0: push_tx(CH_CR, 1'b0);
            1: push_tx(CH_LF, 1'b0);
            default: begin
                push_tx(CH_CR, 1'b0);
                push_tx(CH_LF, 1'b0);
            end
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_byte(input logic [7:0] d, input logic l);
        while ($urandom_range(0, 99) < send_idle) begin
            tx_valid = 1'b0;
            @(negedge i_clk);
        end
        tx_valid = 1'b1;
        tx_data  = d;
        tx_last  = l;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sb.note_byte(d, l);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_byte(text_q[i].d, text_q[i].l);
        text_q.delete();
    endtask

    task automatic hold_until_drained();
        int guard;
        guard = 0;
        tx_valid = 1'b0;
        while (sb.expected.size() > 0 && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        // items that make no result may still be in flight
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_sep(input logic [7:0] v);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        sb.set_separator(v);
        n_seps++;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_phase(input int n_items, input bit wide);
        int         start;
        int         pick;
        int         nrows;
        int         nf;
        bit         paused;
        t_text_byte t;
        start  = items_sent;
        paused = 0;
        if (wide) begin
            // push the field counter past saturation
            repeat (260) push_tx(sb.sep, 1'b0);
            push_tx(pick_plain(), 1'b1);
            send_text();
        end
        while (items_sent - start < n_items) begin
            if (!paused && items_sent - start >= n_items / 2) begin
                paused = 1;
                hold_until_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                repeat ($urandom_range(1, 10))
                    push_tx(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
            end else if (pick < 20) begin
                // quoted field cut off by the end of text
                push_tx(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 3))
                    push_tx(8'($urandom_range(0, 255)), 1'b0);
                push_tx($urandom_range(0, 1) ? CH_QUOTE : pick_plain(), 1'b1);
            end else begin
                nrows = $urandom_range(1, 4);
                for (int r = 0; r < nrows; r++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        add_line_end();
                    end else begin
                        nf = $urandom_range(1, 5);
                        for (int f = 0; f < nf; f++) begin
                            if (f > 0)
                                push_tx(sb.sep, 1'b0);
                            add_field();
                        end
                        if (r < nrows - 1 || $urandom_range(0, 1))
                            add_line_end();
                    end
                end
                if (text_q.size() == 0) begin
                    push_tx(pick_plain(), 1'b1);
                end else begin
                    t = text_q.pop_back();
                    t.l = 1'b1;
                    text_q.push_back(t);
                end
            end
            send_text();
        end
    endtask

    initial begin
        sb = new();
        sep_list = '{8'd59, 8'd0, 8'd255, CH_QUOTE, CH_CR, CH_LF, 8'd9, 8'd0, SEP_RESET};
        sep_list[7] = 8'($urandom_range(0, 255));
        repeat (9) @(negedge i_clk);
        rst_n = 1'b1;

        // directed text under the reset separator
        push_tx(8'h00, 1'b0);
        push_tx(8'hFF, 1'b0);
        push_tx(",", 1'b0);
        push_tx(CH_QUOTE, 1'b0);
        push_tx("q", 1'b0);
        push_tx(CH_QUOTE, 1'b0);
        push_tx(CH_QUOTE, 1'b0);
        push_tx(CH_QUOTE, 1'b0);
        push_tx(",", 1'b0);
        push_tx("a", 1'b0);
        push_tx(CH_QUOTE, 1'b0);
        push_tx(CH_LF, 1'b0);
        push_tx(CH_CR, 1'b0);
        push_tx(CH_LF, 1'b0);
        push_tx(CH_QUOTE, 1'b0);
        push_tx(CH_QUOTE, 1'b0);
        push_tx(CH_CR, 1'b0);
        push_tx(",", 1'b0);
        push_tx(CH_CR, 1'b0);
        push_tx(CH_CR, 1'b0);
        push_tx("z", 1'b1);
        push_tx(CH_QUOTE, 1'b0);
        push_tx("k", 1'b0);
        push_tx(CH_QUOTE, 1'b1);
        push_tx(CH_LF, 1'b1);
        send_text();

        for (int p = 0; p < PHASES; p++) begin
            hold_until_drained();
            case (p % 4)
                0: begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1: begin
                    send_idle  = 88;
                    recv_stall = 0;
                end
                2: begin
                    send_idle  = 0;
                    recv_stall = 88;
                end
                default: begin
                    send_idle  = 18;
                    recv_stall = 18;
                end
            endcase
            write_sep(sep_list[p]);
            run_phase(185, p == 0 || p == 2);
        end

        hold_until_drained();
        sb.drain_check();
        $display("Sent %0d bytes under %0d separator writes; checked %0d results, %0d row ends.",
                 sb.n_bytes, n_seps, sb.n_results, sb.n_rows);
        $display("Idling covered none, sender only, receiver only and both sides.");
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
